### rtl/btn_dbnc_pkg.sv
// shared types and constants for the button debounce and press detection unit
package btn_dbnc_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned DEB_W  = 16;
    localparam int unsigned IDX_W  = 2;

    typedef logic [1:0] press_event_t;

    localparam press_event_t EV_NONE  = 2'd0;
    localparam press_event_t EV_SHORT = 2'd1;
    localparam press_event_t EV_LONG  = 2'd2;

    typedef logic [IDX_W-1:0] reg_index_t;

    localparam reg_index_t REG_ENABLE     = 2'd0;
    localparam reg_index_t REG_DEBOUNCE   = 2'd1;
    localparam reg_index_t REG_LONG_PRESS = 2'd2;

    localparam logic [DEB_W-1:0]  DEBOUNCE_RESET   = 16'd50;
    localparam logic [TIME_W-1:0] LONG_PRESS_RESET = 32'd1000;

endpackage

### rtl/button_debounce_short_long_press_unit.sv
// button debouncer with short and long press detection
// a sample beat is registered in the input stage, then its result in the output stage
// throughput: one sample per cycle while m_ready does not stall the output; the only loop is the state update
// reset: synchronous active low; stable level released, no press active,
// registers back to enable 0, debounce 50 ms, long press 1000 ms
module button_debounce_short_long_press_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  btn_dbnc_pkg::reg_index_t          cfg_index,
    input  logic [btn_dbnc_pkg::TIME_W-1:0]   cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_raw_level,
    input  logic [btn_dbnc_pkg::TIME_W-1:0]   s_now_ms,
    output logic                              m_valid,
    input  logic                              m_ready,
    output btn_dbnc_pkg::press_event_t        m_press_event,
    output logic                              m_pressed
);
    import btn_dbnc_pkg::*;

    logic                enable_reg;
    logic [DEB_W-1:0]    debounce_reg;
    logic [TIME_W-1:0]   long_press_reg;

    logic                in_vld_reg;
    logic                in_raw_reg;
    logic [TIME_W-1:0]   in_now_reg;

    logic                last_raw_reg,     last_raw_next;
    logic [TIME_W-1:0]   last_change_reg,  last_change_next;
    logic                stable_reg,       stable_next;
    logic                active_reg,       active_next;
    logic [TIME_W-1:0]   start_reg,        start_next;
    logic                fired_reg,        fired_next;

    logic                out_vld_reg;
    press_event_t        event_reg,        event_next;
    logic                pressed_reg,      pressed_next;

    logic                advance;
    logic [TIME_W-1:0]   since_change;
    logic [TIME_W-1:0]   hold_time;

    assign advance   = !out_vld_reg || m_ready;
    assign s_ready   = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_valid       = out_vld_reg;
    assign m_press_event = event_reg;
    assign m_pressed     = pressed_reg;

    always_comb begin
        last_raw_next    = last_raw_reg;
        last_change_next = last_change_reg;
        stable_next      = stable_reg;
        active_next      = active_reg;
        start_next       = start_reg;
        fired_next       = fired_reg;
        event_next       = EV_NONE;
        pressed_next     = 1'b0;

        if (in_raw_reg != last_raw_reg) begin
            last_change_next = in_now_reg;
        end
        since_change = in_now_reg - last_change_next;

        if (enable_reg) begin
            last_raw_next = in_raw_reg;
            if (since_change > {{(TIME_W-DEB_W){1'b0}}, debounce_reg} &&
                in_raw_reg != stable_reg) begin
                stable_next = in_raw_reg;
                if (!in_raw_reg) begin
                    active_next = 1'b1;
                    start_next  = in_now_reg;
                    fired_next  = 1'b0;
                end else begin
                    if (active_reg && !fired_reg) begin
                        event_next = EV_SHORT;
                    end
                    active_next = 1'b0;
                end
            end
        end else begin
            last_change_next = last_change_reg;
        end

        // hold time is measured against the start that this sample may have set
        hold_time = in_now_reg - start_next;
        if (enable_reg && active_next && !fired_next && !stable_next &&
            hold_time >= long_press_reg) begin
            fired_next = 1'b1;
            event_next = EV_LONG;
        end

        pressed_next = enable_reg && !stable_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg      <= 1'b0;
            debounce_reg    <= DEBOUNCE_RESET;
            long_press_reg  <= LONG_PRESS_RESET;
            in_vld_reg      <= 1'b0;
            out_vld_reg     <= 1'b0;
            last_raw_reg    <= 1'b1;
            last_change_reg <= '0;
            stable_reg      <= 1'b1;
            active_reg      <= 1'b0;
            start_reg       <= '0;
            fired_reg       <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_ENABLE:     enable_reg     <= cfg_data[0];
                    REG_DEBOUNCE:   debounce_reg   <= cfg_data[DEB_W-1:0];
                    REG_LONG_PRESS: long_press_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (s_ready) begin
                in_vld_reg <= s_valid;
            end

            if (advance) begin
                out_vld_reg <= in_vld_reg;
                if (in_vld_reg) begin
                    last_raw_reg    <= last_raw_next;
                    last_change_reg <= last_change_next;
                    stable_reg      <= stable_next;
                    active_reg      <= active_next;
                    start_reg       <= start_next;
                    fired_reg       <= fired_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_raw_reg <= s_raw_level;
            in_now_reg <= s_now_ms;
        end
        if (advance && in_vld_reg) begin
            event_reg   <= event_next;
            pressed_reg <= pressed_next;
        end
    end

endmodule

### rtl/btn_dbnc_checker.sv
// port-level checker for the button debounce unit and its bind
module btn_dbnc_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  btn_dbnc_pkg::press_event_t m_press_event,
    input  logic                       m_pressed
);
    import btn_dbnc_pkg::*;

    // result channel is empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat valid after reset");

    // a stalled result beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_press_event) && $stable(m_pressed))
        else $error("stalled result beat changed");

    a_event_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_press_event == EV_NONE || m_press_event == EV_SHORT ||
                     m_press_event == EV_LONG))
        else $error("undefined press event code");

    // a short press comes only on release
    a_short_released: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_press_event == EV_SHORT |-> !m_pressed)
        else $error("short press reported while pressed");

    // a long press fires only while held
    a_long_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_press_event == EV_LONG |-> m_pressed)
        else $error("long press reported while released");

endmodule

bind button_debounce_short_long_press_unit btn_dbnc_checker u_btn_dbnc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_press_event (m_press_event),
    .m_pressed     (m_pressed)
);
